### design/dsa_pkg.sv
// dsa_pkg: shared constants, codes and helper functions of the decimal scaled arithmetic unit
// no dependencies; imported by the channel interfaces and decimal_scaled_arithmetic

package dsa_pkg;

  // payload field widths
  localparam int MAG_W  = 60;
  localparam int SC_W   = 5;
  localparam int KIND_W = 3;

  // parameter defaults
  localparam int DEF_MAX_DIGITS = 18;
  localparam int DEF_MAX_SCALE  = 18;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_ADD     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUB     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MUL     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIV     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CMP     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RESCALE = 3'd5;

  // status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_OVF  = 2'd1;
  localparam logic [1:0] STAT_DIVZ = 2'd2;

  // compare outcome codes
  localparam logic [1:0] ORD_NONE = 2'd0;
  localparam logic [1:0] ORD_LT   = 2'd0;
  localparam logic [1:0] ORD_EQ   = 2'd1;
  localparam logic [1:0] ORD_GT   = 2'd2;

  // largest magnitude: 10^digits - 1, capped at the field width
  function automatic logic [MAG_W-1:0] mag_limit(input int digits);
    logic [63:0] lim;
    lim = 64'd1;
    for (int i = 0; i < digits; i++) begin
      lim = lim * 64'd10;
    end
    lim = lim - 64'd1;
    if (lim > {{(64-MAG_W){1'b0}}, {MAG_W{1'b1}}}) begin
      return {MAG_W{1'b1}};
    end
    return lim[MAG_W-1:0];
  endfunction

endpackage

### design/dsa_in_if.sv
// dsa_in_if, dsa_out_if: valid/ready channels carrying operation items and results
// depends on dsa_pkg for the field widths

interface dsa_in_if;
  import dsa_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic              a_negative;
  logic [MAG_W-1:0]  a_magnitude;
  logic [SC_W-1:0]   a_scale;
  logic              b_negative;
  logic [MAG_W-1:0]  b_magnitude;
  logic [SC_W-1:0]   b_scale;
  logic [SC_W-1:0]   target_scale;

  modport source (output valid, kind, a_negative, a_magnitude, a_scale,
                  b_negative, b_magnitude, b_scale, target_scale, input ready);
  modport sink   (input valid, kind, a_negative, a_magnitude, a_scale,
                  b_negative, b_magnitude, b_scale, target_scale, output ready);
endinterface

interface dsa_out_if;
  import dsa_pkg::*;
  logic             valid;
  logic             ready;
  logic             res_negative;
  logic [MAG_W-1:0] res_magnitude;
  logic [1:0]       order;
  logic [1:0]       status;

  modport source (output valid, res_negative, res_magnitude, order, status, input ready);
  modport sink   (input valid, res_negative, res_magnitude, order, status, output ready);
endinterface

### design/dsa_divider.sv
// dsa_divider: restoring long divider, one quotient bit per cycle
// no package dependencies; used by decimal_scaled_arithmetic

module dsa_divider #(
  parameter int W = 196
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  localparam int CW = $clog2(W);

  logic          run_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  q_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  div_r;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;
  logic [W-1:0]  rem_nxt;

  // trial subtract of the shifted partial remainder
  assign trial   = {rem_r, q_r[W-1]};
  assign diff    = trial - {1'b0, div_r};
  assign ge      = (trial >= {1'b0, div_r});
  assign rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (run_r) begin
      q_r   <= {q_r[W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

### design/decimal_scaled_arithmetic.sv
// decimal_scaled_arithmetic: sign-magnitude decimal add, subtract, multiply, divide,
// compare and rescale with half-up rounding and saturation
// depends on dsa_pkg, dsa_in_if/dsa_out_if and dsa_divider
//
// Usage: in_ch carries one operation (kind, two signed scaled operands, target scale);
// out_ch returns one result per item (sign, magnitude at target scale, order, status).
// One item is worked at a time; in_ch.ready is high only while the sequencer is idle.
// The work depends on the operation, with each scale step on the shared
// multiply-by-ten adder and each division on the one bit-serial divider
// (W = 2*60 + 4*MAX_SCALE + 4, 196 by default):
//   compare: |a_scale - b_scale| scale steps to align, then the compare
//   add, subtract, rescale: scale steps, plus scale steps and a division to round down
//   multiply: shift-add over the 60 bits of b, then the rescale above
//   divide: up to two divisions plus scale steps, then one more division to round
// A result sits in the output register until taken; the sequencer may finish the next
// item meanwhile and holds it until the output register frees, so a stalled receiver
// only delays the block. Reset (rst_n low, synchronous) empties the output register and
// returns the sequencer to idle. There is no configuration and no state between items.

module decimal_scaled_arithmetic #(
  parameter int MAX_DIGITS = dsa_pkg::DEF_MAX_DIGITS,
  parameter int MAX_SCALE  = dsa_pkg::DEF_MAX_SCALE
) (
  input  logic       clk,
  input  logic       rst_n,
  dsa_in_if.sink     in_ch,
  dsa_out_if.source  out_ch
);
  import dsa_pkg::*;

  localparam int W  = 2 * MAG_W + 4 * MAX_SCALE + 4;
  localparam int CW = $clog2(W + 1);
  localparam logic [MAG_W-1:0] LIMIT  = mag_limit(MAX_DIGITS);
  localparam logic [CW-1:0]    SC_MAX = CW'(MAX_SCALE);

  // sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_ALIGN  = 5'd1;
  localparam logic [4:0] S_ADDSUB = 5'd2;
  localparam logic [4:0] S_MUL    = 5'd3;
  localparam logic [4:0] S_DUP    = 5'd4;
  localparam logic [4:0] S_DPOW   = 5'd5;
  localparam logic [4:0] S_DQ1    = 5'd6;
  localparam logic [4:0] S_DW1    = 5'd7;
  localparam logic [4:0] S_DQ2    = 5'd8;
  localparam logic [4:0] S_DW2    = 5'd9;
  localparam logic [4:0] S_FIN    = 5'd10;
  localparam logic [4:0] S_UP     = 5'd11;
  localparam logic [4:0] S_POW    = 5'd12;
  localparam logic [4:0] S_FDIV   = 5'd13;
  localparam logic [4:0] S_FWAIT  = 5'd14;
  localparam logic [4:0] S_ROUND  = 5'd15;
  localparam logic [4:0] S_SAT    = 5'd16;
  localparam logic [4:0] S_EMIT   = 5'd17;

  function automatic logic [CW-1:0] clamp_sc(input logic [SC_W-1:0] s);
    logic [CW-1:0] w;
    w = CW'(s);
    return (w > SC_MAX) ? SC_MAX : w;
  endfunction

  logic [4:0]       state_r;
  logic [W-1:0]     a_r, b_r, d_r, v_r;
  logic [CW-1:0]    cnt_r, cntb_r, from_r;
  logic [CW-1:0]    as_r, bs_r, ts_r;
  logic             an_r, bn_r, sign_r, rnd_r;
  logic [KIND_W-1:0] kind_r;
  logic             st_neg_r;
  logic [MAG_W-1:0] st_mag_r;
  logic [1:0]       st_ord_r, st_stat_r;
  logic             out_valid_r;
  logic             out_neg_r;
  logic [MAG_W-1:0] out_mag_r;
  logic [1:0]       out_ord_r, out_stat_r;

  logic             in_xfer, out_xfer, emit;
  logic [CW-1:0]    in_as, in_bs, in_ts, in_s, in_up;
  logic [CW-1:0]    s_ab;
  logic [W-1:0]     m10_in, m10_out;
  logic             div_start, div_done;
  logic [W-1:0]     div_dividend, div_divisor, div_q, div_rem;
  logic             c_gt, c_eq, na, nb;
  logic [1:0]       ord_c;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_valid_r && out_ch.ready;
  assign emit        = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  // clamped scales of the incoming item
  assign in_as = clamp_sc(in_ch.a_scale);
  assign in_bs = clamp_sc(in_ch.b_scale);
  assign in_ts = clamp_sc(in_ch.target_scale);
  assign in_s  = (in_as > in_bs) ? in_as : in_bs;
  assign in_up = in_ts + in_bs + 1'b1;
  assign s_ab  = (as_r > bs_r) ? as_r : bs_r;

  // shared multiply-by-ten unit
  always_comb begin
    case (state_r)
      S_ALIGN:       m10_in = (cnt_r != '0) ? a_r : b_r;
      S_DUP:         m10_in = a_r;
      S_DPOW, S_POW: m10_in = d_r;
      default:       m10_in = v_r;
    endcase
  end
  assign m10_out = {m10_in[W-4:0], 3'b000} + {m10_in[W-2:0], 1'b0};

  // divider hookup
  assign div_start    = (state_r == S_DQ1) || (state_r == S_DQ2) || (state_r == S_FDIV);
  assign div_dividend = (state_r == S_FDIV) ? v_r : a_r;
  assign div_divisor  = (state_r == S_DQ2) ? b_r : d_r;

  dsa_divider #(.W(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // compare of aligned operands
  assign c_gt = (a_r > b_r);
  assign c_eq = (a_r == b_r);
  assign na   = an_r && (a_r != '0);
  assign nb   = bn_r && (b_r != '0);
  always_comb begin
    if (na != nb) begin
      ord_c = na ? ORD_LT : ORD_GT;
    end else if (c_eq) begin
      ord_c = ORD_EQ;
    end else if (c_gt != na) begin
      ord_c = ORD_GT;
    end else begin
      ord_c = ORD_LT;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            case (in_ch.kind)
              KIND_ADD, KIND_SUB, KIND_CMP: state_r <= S_ALIGN;
              KIND_MUL:     state_r <= S_MUL;
              KIND_DIV: begin
                if (in_ch.b_magnitude == '0) begin
                  state_r <= S_EMIT;
                end else if (in_up >= in_as) begin
                  state_r <= S_DUP;
                end else begin
                  state_r <= S_DPOW;
                end
              end
              KIND_RESCALE: state_r <= S_FIN;
              default:      state_r <= S_EMIT;
            endcase
          end
        end
        S_ALIGN: begin
          if (cnt_r == '0 && cntb_r == '0) begin
            state_r <= S_ADDSUB;
          end
        end
        S_ADDSUB: state_r <= (kind_r == KIND_CMP) ? S_EMIT : S_FIN;
        S_MUL: begin
          if (cnt_r == CW'(1)) begin
            state_r <= S_FIN;
          end
        end
        S_DUP: begin
          if (cnt_r == '0) begin
            state_r <= S_DQ2;
          end
        end
        S_DPOW: begin
          if (cnt_r == '0) begin
            state_r <= S_DQ1;
          end
        end
        S_DQ1: state_r <= S_DW1;
        S_DW1: begin
          if (div_done) begin
            state_r <= S_DQ2;
          end
        end
        S_DQ2: state_r <= S_DW2;
        S_DW2: begin
          if (div_done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (from_r < ts_r) begin
            state_r <= S_UP;
          end else if (from_r > ts_r) begin
            state_r <= S_POW;
          end else begin
            state_r <= S_SAT;
          end
        end
        S_UP: begin
          if (cnt_r == '0) begin
            state_r <= S_SAT;
          end
        end
        S_POW: begin
          if (cnt_r == '0) begin
            state_r <= S_FDIV;
          end
        end
        S_FDIV: state_r <= S_FWAIT;
        S_FWAIT: begin
          if (div_done) begin
            state_r <= S_ROUND;
          end
        end
        S_ROUND: state_r <= S_SAT;
        S_SAT:   state_r <= S_EMIT;
        S_EMIT: begin
          if (emit) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          kind_r    <= in_ch.kind;
          a_r       <= W'(in_ch.a_magnitude);
          b_r       <= W'(in_ch.b_magnitude);
          an_r      <= in_ch.a_negative;
          bn_r      <= in_ch.b_negative ^ (in_ch.kind == KIND_SUB);
          as_r      <= in_as;
          bs_r      <= in_bs;
          ts_r      <= in_ts;
          d_r       <= W'(1);
          cntb_r    <= in_s - in_bs;
          st_neg_r  <= 1'b0;
          st_mag_r  <= '0;
          st_ord_r  <= ORD_NONE;
          case (in_ch.kind)
            KIND_MUL: begin
              v_r       <= '0;
              cnt_r     <= CW'(MAG_W);
              from_r    <= in_as + in_bs;
              sign_r    <= in_ch.a_negative ^ in_ch.b_negative;
              st_stat_r <= STAT_OK;
            end
            KIND_DIV: begin
              v_r       <= W'(in_ch.a_magnitude);
              sign_r    <= in_ch.a_negative ^ in_ch.b_negative;
              cnt_r     <= (in_up >= in_as) ? (in_up - in_as) : (in_as - in_up);
              from_r    <= in_ts + 1'b1;
              st_stat_r <= (in_ch.b_magnitude == '0) ? STAT_DIVZ : STAT_OK;
            end
            default: begin
              v_r       <= W'(in_ch.a_magnitude);
              cnt_r     <= in_s - in_as;
              from_r    <= in_as;
              sign_r    <= in_ch.a_negative;
              st_stat_r <= STAT_OK;
            end
          endcase
        end
      end
      S_ALIGN: begin
        if (cnt_r != '0) begin
          a_r   <= m10_out;
          cnt_r <= cnt_r - 1'b1;
        end else if (cntb_r != '0) begin
          b_r    <= m10_out;
          cntb_r <= cntb_r - 1'b1;
        end
      end
      S_ADDSUB: begin
        from_r   <= s_ab;
        // order is only reported for a compare
        st_ord_r <= (kind_r == KIND_CMP) ? ord_c : ORD_NONE;
        if (an_r == bn_r) begin
          v_r    <= a_r + b_r;
          sign_r <= an_r;
        end else if (c_gt || c_eq) begin
          v_r    <= a_r - b_r;
          sign_r <= an_r;
        end else begin
          v_r    <= b_r - a_r;
          sign_r <= bn_r;
        end
      end
      S_MUL: begin
        if (b_r[0]) begin
          v_r <= v_r + a_r;
        end
        a_r   <= {a_r[W-2:0], 1'b0};
        b_r   <= {1'b0, b_r[W-1:1]};
        cnt_r <= cnt_r - 1'b1;
      end
      S_DUP: begin
        if (cnt_r != '0) begin
          a_r   <= m10_out;
          cnt_r <= cnt_r - 1'b1;
        end
      end
      S_DPOW, S_POW: begin
        if (cnt_r != '0) begin
          d_r   <= m10_out;
          cnt_r <= cnt_r - 1'b1;
        end
      end
      S_DW1: begin
        if (div_done) begin
          a_r <= div_q;
        end
      end
      S_DW2: begin
        if (div_done) begin
          v_r <= div_q;
        end
      end
      S_FIN: begin
        d_r   <= W'(1);
        cnt_r <= (from_r < ts_r) ? (ts_r - from_r) : (from_r - ts_r);
      end
      S_UP: begin
        if (cnt_r != '0) begin
          v_r   <= m10_out;
          cnt_r <= cnt_r - 1'b1;
        end
      end
      S_FWAIT: begin
        if (div_done) begin
          v_r   <= div_q;
          rnd_r <= (div_rem >= {1'b0, d_r[W-1:1]});
        end
      end
      S_ROUND: v_r <= v_r + W'(rnd_r);
      S_SAT: begin
        if (v_r > W'(LIMIT)) begin
          st_neg_r  <= sign_r;
          st_mag_r  <= LIMIT;
          st_stat_r <= STAT_OVF;
        end else begin
          st_neg_r  <= sign_r && (v_r[MAG_W-1:0] != '0);
          st_mag_r  <= v_r[MAG_W-1:0];
          st_stat_r <= STAT_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_neg_r  <= st_neg_r;
      out_mag_r  <= st_mag_r;
      out_ord_r  <= st_ord_r;
      out_stat_r <= st_stat_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.res_negative  = out_neg_r;
  assign out_ch.res_magnitude = out_mag_r;
  assign out_ch.order         = out_ord_r;
  assign out_ch.status        = out_stat_r;

`ifndef SYNTHESIS
  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready)
    else $error("input taken while an item is in progress");

  // divide by zero gives a clean zero result
  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == STAT_DIVZ) |->
      (out_ch.res_magnitude == '0 && !out_ch.res_negative))
    else $error("divide by zero result not zero");

  // magnitude never above the limit
  a_mag_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.res_magnitude <= LIMIT))
    else $error("result magnitude above limit");

  // a compare outcome comes with an empty arithmetic result
  a_order_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.order != ORD_NONE) |->
      (out_ch.res_magnitude == '0 && out_ch.status == STAT_OK && !out_ch.res_negative))
    else $error("compare outcome mixed with arithmetic result");

  // no new result while the held one is stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_valid_r && $stable(out_mag_r)))
    else $error("stalled result overwritten");
`endif

endmodule
